// ----- hdl/sfc_pkg.sv -----
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared constants, codes and helpers for the source MAC frame counter.
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam int ENTRIES    = 256;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int MAC_W      = 48;
    localparam int COUNT_BITS = 32;
    localparam int ADD_W      = 7;
    localparam int SLOT_W     = 8;
    localparam int CFG_W      = 32;
    localparam logic [CFG_W-1:0] CLR_INTERVAL_RST = 32'd10000;

    typedef enum logic [1:0] {
        FUNC_FRAME = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_COUNTED = 2'd0,
        ST_NEW     = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOFRAME = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ
    } t_state;

    // Saturating counter add.
    function automatic logic [COUNT_BITS-1:0] sat_add(
        input logic [COUNT_BITS-1:0] cnt,
        input logic [ADD_W-1:0]      add
    );
        logic [COUNT_BITS:0] sum;
        sum = {1'b0, cnt} + (COUNT_BITS+1)'(add);
        sat_add = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
    endfunction

endpackage

// ----- hdl/sfc_ram.sv -----
// ----------------------------------------------------------------------------
// sfc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sfc_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ----- hdl/source_mac_frame_counter_core.sv -----
// ----------------------------------------------------------------------------
// source_mac_frame_counter_core
// Per source MAC frame statistics table with periodic clearing.
// ----------------------------------------------------------------------------
// Frame item: linear scan of the table RAM, one entry per cycle, with early
//   exit on a hit. Read item: registered RAM read, then registered result.
// Tick or unused item: result registered straight from idle.
// One item at a time; busy is high while a frame scan or slot read runs.
// Synchronous active-low reset clears valid marks and ticks, reloads interval.
// Results are strobed for one cycle; the receiver cannot stall.
module source_mac_frame_counter_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_func,
    input  logic [sfc_pkg::MAC_W-1:0]      i_src_mac,
    input  logic [5:0]                     i_frag_count,
    input  logic [sfc_pkg::SLOT_W-1:0]     i_read_slot,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sfc_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                           o_done,
    output logic [1:0]                     o_status,
    output logic [sfc_pkg::SLOT_W-1:0]     o_slot,
    output logic                           o_entry_valid,
    output logic [sfc_pkg::MAC_W-1:0]      o_entry_mac,
    output logic [31:0]                    o_entry_count,
    output logic                           o_cleared
);
    import sfc_pkg::*;

    localparam int RAM_W = MAC_W + COUNT_BITS;

    t_state r_state, n_state;
    logic [IDX_W:0]        r_idx, n_idx;
    logic                  r_chk, n_chk;
    logic [IDX_W-1:0]      r_chk_idx, n_chk_idx;
    logic                  r_free_ok, n_free_ok;
    logic [IDX_W-1:0]      r_free_idx, n_free_idx;
    logic [MAC_W-1:0]      r_mac, n_mac;
    logic [ADD_W-1:0]      r_add, n_add;
    logic [SLOT_W-1:0]     r_rslot, n_rslot;
    logic [ENTRIES-1:0]    r_valid;
    logic [CFG_W-1:0]      r_ticks, r_interval;

    logic                  r_done, n_done;
    logic [1:0]            r_status, n_status;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic                  r_evalid, n_evalid;
    logic [MAC_W-1:0]      r_emac, n_emac;
    logic [31:0]           r_ecount, n_ecount;
    logic                  r_cleared, n_cleared;

    logic                  accept;
    logic                  tick_clear;
    logic [CFG_W-1:0]      ticks_inc, limit;
    logic                  we, set_valid;
    logic [IDX_W-1:0]      waddr, raddr;
    logic [RAM_W-1:0]      wdata, rdata;
    logic [MAC_W-1:0]      q_mac;
    logic [COUNT_BITS-1:0] q_cnt, hit_cnt;
    logic                  hit, last, free_now, have_free, rd_live;
    logic [IDX_W-1:0]      free_sel;

    sfc_ram #(.WIDTH(RAM_W), .DEPTH(ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign q_mac     = rdata[RAM_W-1:COUNT_BITS];
    assign q_cnt     = rdata[COUNT_BITS-1:0];
    assign hit_cnt   = sat_add(q_cnt, r_add);
    assign hit       = r_chk && r_valid[r_chk_idx] && (q_mac == r_mac);
    assign last      = r_chk && (r_chk_idx == IDX_W'(ENTRIES-1));
    assign free_now  = r_chk && !r_valid[r_chk_idx];
    assign have_free = r_free_ok || free_now;
    assign free_sel  = r_free_ok ? r_free_idx : r_chk_idx;
    assign rd_live   = ({1'b0, r_rslot} < (SLOT_W+1)'(ENTRIES))
                       && r_valid[r_rslot[IDX_W-1:0]];

    assign ticks_inc  = (r_ticks == {CFG_W{1'b1}}) ? r_ticks : r_ticks + 1'b1;
    assign limit      = (r_interval == '0) ? CFG_W'(1) : r_interval;
    assign tick_clear = accept && (t_func'(i_func) == FUNC_TICK) && (ticks_inc >= limit);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && t_func'(i_func) == FUNC_FRAME) begin
                    n_state = S_SCAN;
                end else if (accept && t_func'(i_func) == FUNC_READ) begin
                    n_state = S_READ;
                end
            end
            S_SCAN: begin
                if (hit || last) begin
                    n_state = S_IDLE;
                end
            end
            S_READ:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_idx      = r_idx;
        n_chk      = 1'b0;
        n_chk_idx  = r_idx[IDX_W-1:0];
        n_free_ok  = r_free_ok;
        n_free_idx = r_free_idx;
        n_mac      = r_mac;
        n_add      = r_add;
        n_rslot    = r_rslot;
        raddr      = r_idx[IDX_W-1:0];
        we         = 1'b0;
        set_valid  = 1'b0;
        waddr      = r_chk_idx;
        wdata      = {r_mac, hit_cnt};
        n_done     = 1'b0;
        n_status   = ST_NOFRAME;
        n_slot     = '0;
        n_evalid   = 1'b0;
        n_emac     = '0;
        n_ecount   = '0;
        n_cleared  = 1'b0;
        case (r_state)
            S_IDLE: begin
                raddr   = i_read_slot[IDX_W-1:0];
                n_mac   = i_src_mac;
                n_add   = ADD_W'(i_frag_count) + ADD_W'(1);
                n_rslot = i_read_slot;
                n_idx   = '0;
                n_free_ok = 1'b0;
                if (accept && t_func'(i_func) != FUNC_FRAME
                    && t_func'(i_func) != FUNC_READ) begin
                    n_done    = 1'b1;
                    n_cleared = tick_clear;
                end
            end
            S_SCAN: begin
                // issue the next address while checking the previous one
                n_chk     = (r_idx < (IDX_W+1)'(ENTRIES));
                n_idx     = r_idx + 1'b1;
                if (free_now && !r_free_ok) begin
                    n_free_ok  = 1'b1;
                    n_free_idx = r_chk_idx;
                end
                if (hit) begin
                    we       = 1'b1;
                    n_done   = 1'b1;
                    n_status = ST_COUNTED;
                    n_slot   = SLOT_W'(r_chk_idx);
                    n_evalid = 1'b1;
                    n_emac   = r_mac;
                    n_ecount = hit_cnt[31:0];
                end else if (last) begin
                    n_done = 1'b1;
                    if (have_free) begin
                        we        = 1'b1;
                        set_valid = 1'b1;
                        waddr     = free_sel;
                        wdata     = {r_mac, COUNT_BITS'(r_add)};
                        n_status  = ST_NEW;
                        n_slot    = SLOT_W'(free_sel);
                        n_evalid  = 1'b1;
                        n_emac    = r_mac;
                        n_ecount  = 32'(r_add);
                    end else begin
                        n_status = ST_FULL;
                    end
                end
            end
            S_READ: begin
                n_done = 1'b1;
                n_slot = r_rslot;
                if (rd_live) begin
                    n_evalid = 1'b1;
                    n_emac   = q_mac;
                    n_ecount = q_cnt[31:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_chk      <= 1'b0;
            r_free_ok  <= 1'b0;
            r_valid    <= '0;
            r_ticks    <= '0;
            r_interval <= CLR_INTERVAL_RST;
            r_done     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_chk     <= n_chk;
            r_free_ok <= n_free_ok;
            r_done    <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_interval <= i_cfg_data;
            end
            if (accept && t_func'(i_func) == FUNC_TICK) begin
                r_ticks <= tick_clear ? '0 : ticks_inc;
            end
            if (tick_clear) begin
                r_valid <= '0;
            end else if (set_valid) begin
                r_valid[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_chk_idx  <= n_chk_idx;
        r_free_idx <= n_free_idx;
        r_mac      <= n_mac;
        r_add      <= n_add;
        r_rslot    <= n_rslot;
        r_status   <= n_status;
        r_slot     <= n_slot;
        r_evalid   <= n_evalid;
        r_emac     <= n_emac;
        r_ecount   <= n_ecount;
        r_cleared  <= n_cleared;
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_slot        = r_slot;
    assign o_entry_valid = r_evalid;
    assign o_entry_mac   = r_emac;
    assign o_entry_count = r_ecount;
    assign o_cleared     = r_cleared;
endmodule

// ----- hdl/sfc_checker.sv -----
// ----------------------------------------------------------------------------
// sfc_checker
// Port-level checks for the source MAC frame counter.
// ----------------------------------------------------------------------------
module sfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_func,
    input logic        o_done,
    input logic [1:0]  o_status,
    input logic        o_entry_valid,
    input logic        o_cleared
);
    import sfc_pkg::*;

    // A tick item answers on the next cycle.
    a_tick_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FUNC_TICK) |=> o_done)
        else $error("tick item not answered in one cycle");

    // A frame scan holds the block busy.
    a_frame_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FUNC_FRAME) |=> busy)
        else $error("frame item did not start a scan");

    // Dropped frames report no entry.
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_FULL) |-> !o_entry_valid)
        else $error("dropped frame reported an entry");

    // Only a tick result may report a clear.
    a_clear_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_cleared) |-> (o_status == ST_NOFRAME && !o_entry_valid))
        else $error("clear reported outside a tick result");
endmodule

bind source_mac_frame_counter_core sfc_checker u_sfc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_func        (i_func),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_entry_valid (o_entry_valid),
    .o_cleared     (o_cleared)
);

// ----- test/source_mac_frame_counter_core_tb.sv -----
// ----------------------------------------------------------------------------
// source_mac_frame_counter_core_tb
// Drives frame, tick, read and unused items through the MAC statistics table,
// predicts every result with a local table model and checks it field by field.
// ----------------------------------------------------------------------------
module source_mac_frame_counter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sfc_pkg::*;

    typedef struct {
        logic        is_cfg;
        logic [31:0] cfg;
        t_func       func;
        logic [47:0] mac;
        logic [5:0]  frag;
        logic [7:0]  rslot;
    } t_item;

    typedef struct {
        t_status     status;
        logic [7:0]  slot;
        logic        valid;
        logic [47:0] mac;
        logic [31:0] count;
        logic        cleared;
    } t_entry_rpt;

    logic i_clk, i_rst_n, start, busy, i_cfg_valid, o_cfg_ready, o_done;
    logic [1:0] i_func, o_status;
    logic [47:0] i_src_mac, o_entry_mac;
    logic [5:0] i_frag_count;
    logic [7:0] i_read_slot, o_slot;
    logic [31:0] i_cfg_data, o_entry_count;
    logic o_entry_valid, o_cleared;

    source_mac_frame_counter_core i_dut (.*);

    // table model
    logic        tbl_valid [ENTRIES];
    logic [47:0] tbl_mac [ENTRIES];
    logic [31:0] tbl_count [ENTRIES];
    logic [31:0] tick_cnt;
    logic [31:0] interval;

    t_item      pending_q[$];
    t_entry_rpt expected_q[$];
    logic [47:0] mac_pool[$];
    int errors = 0;
    int cycles = 0;
    int gap = 0;
    int settle = 0;

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [6:0] b);
        logic [32:0] s;
        s = {1'b0, a} + 33'(b);
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic t_entry_rpt predict_entry(t_item it);
        t_entry_rpt r;
        logic [31:0] lim;
        r = '{ST_NOFRAME, 8'd0, 1'b0, 48'd0, 32'd0, 1'b0};
        case (it.func)
            FUNC_FRAME: begin
                r.status = ST_FULL;
                for (int i = 0; i < ENTRIES; i++)
                    if (r.status == ST_FULL && tbl_valid[i] && tbl_mac[i] == it.mac) begin
                        tbl_count[i] = add_sat(tbl_count[i], 7'(it.frag) + 7'd1);
                        r = '{ST_COUNTED, 8'(i), 1'b1, it.mac, tbl_count[i], 1'b0};
                    end
                for (int i = 0; i < ENTRIES; i++)
                    if (r.status == ST_FULL && !tbl_valid[i]) begin
                        tbl_valid[i] = 1'b1;
                        tbl_mac[i] = it.mac;
                        tbl_count[i] = 32'(it.frag) + 32'd1;
                        r = '{ST_NEW, 8'(i), 1'b1, it.mac, tbl_count[i], 1'b0};
                    end
            end
            FUNC_TICK: begin
                lim = (interval == 0) ? 32'd1 : interval;
                if (tick_cnt != 32'hFFFF_FFFF) tick_cnt++;
                if (tick_cnt >= lim) begin
                    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
                    tick_cnt = 0;
                    r.cleared = 1'b1;
                end
            end
            FUNC_READ: begin
                r.slot = it.rslot;
                if (tbl_valid[it.rslot]) begin
                    r.valid = 1'b1;
                    r.mac = tbl_mac[it.rslot];
                    r.count = tbl_count[it.rslot];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [47:0] pick_mac();
        if (mac_pool.size() > 0 && $urandom_range(0, 2) != 0)
            return mac_pool[$urandom_range(0, mac_pool.size() - 1)];
        return 48'({$urandom(), $urandom()});
    endfunction

    task automatic add_item(t_func f, logic [47:0] m, logic [5:0] fr, logic [7:0] rs);
        pending_q.push_back('{1'b0, 32'd0, f, m, fr, rs});
    endtask

    task automatic add_cfg(logic [31:0] v);
        pending_q.push_back('{1'b1, v, FUNC_NONE, 48'd0, 6'd0, 8'd0});
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // driver: items and register writes, with random gaps
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            start <= 0;
            i_cfg_valid <= 0;
        end else if (start && !busy) begin
            // item accepted at this edge: queue its expected result
            expected_q.push_back(predict_entry(pending_q.pop_front()));
            start <= 0;
            gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        end else if (i_cfg_valid && o_cfg_ready) begin
            interval <= i_cfg_data;
            void'(pending_q.pop_front());
            i_cfg_valid <= 0;
            settle <= 0;
        end else if (gap > 0) begin
            gap <= gap - 1;
        end else if (pending_q.size() > 0 && !start && !i_cfg_valid) begin
            if (pending_q[0].is_cfg) begin
                // let any scan finish before reprogramming
                if (expected_q.size() == 0 && !busy && settle > 300) begin
                    i_cfg_valid <= 1;
                    i_cfg_data <= pending_q[0].cfg;
                end else if (expected_q.size() == 0 && !busy) begin
                    settle <= settle + 1;
                end
            end else begin
                start <= 1;
                i_func <= pending_q[0].func;
                i_src_mac <= pending_q[0].mac;
                i_frag_count <= pending_q[0].frag;
                i_read_slot <= pending_q[0].rslot;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_entry_rpt e;
        if (i_rst_n && o_done) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result status=%0d", $time, o_status);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_status !== e.status || o_slot !== e.slot || o_entry_valid !== e.valid
                    || o_entry_mac !== e.mac || o_entry_count !== e.count
                    || o_cleared !== e.cleared) begin
                    $display("%0t: mismatch expected st=%0d slot=%0d v=%0b mac=%h cnt=%0d clr=%0b",
                             $time, e.status, e.slot, e.valid, e.mac, e.count, e.cleared);
                    $display("%0t:          actual   st=%0d slot=%0d v=%0b mac=%h cnt=%0d clr=%0b",
                             $time, o_status, o_slot, o_entry_valid, o_entry_mac,
                             o_entry_count, o_cleared);
                    errors++;
                end
            end
        end
    end

    initial begin
        logic [47:0] m;
        int n;
        start = 0; i_cfg_valid = 0; i_func = 0; i_src_mac = 0; i_frag_count = 0;
        i_read_slot = 0; i_cfg_data = 0; i_rst_n = 0;
        foreach (tbl_valid[i]) begin
            tbl_valid[i] = 0; tbl_mac[i] = 0; tbl_count[i] = 0;
        end
        tick_cnt = 0;
        interval = CLR_INTERVAL_RST;

        // directed: extremes, every kind, duplicates, unused kind, reads
        add_item(FUNC_FRAME, 48'hFFFF_FFFF_FFFF, 6'd63, 8'd0);
        add_item(FUNC_FRAME, 48'd0, 6'd0, 8'd0);
        add_item(FUNC_FRAME, 48'hFFFF_FFFF_FFFF, 6'd0, 8'd0);
        add_item(FUNC_FRAME, 48'hAAAA_5555_AAAA, 6'h2A, 8'd0);
        add_item(FUNC_FRAME, 48'h5555_AAAA_5555, 6'h15, 8'd0);
        add_item(FUNC_READ, 48'd0, 6'd0, 8'd0);
        add_item(FUNC_READ, 48'd0, 6'd0, 8'd1);
        add_item(FUNC_READ, 48'd0, 6'd0, 8'd255);
        add_item(FUNC_NONE, 48'hFFFF_FFFF_FFFF, 6'd63, 8'd255);
        add_item(FUNC_TICK, 48'hFFFF_FFFF_FFFF, 6'd63, 8'd170);
        add_cfg(32'd1);
        add_item(FUNC_TICK, 48'd0, 6'd0, 8'd85);
        add_item(FUNC_READ, 48'd0, 6'd0, 8'd0);
        add_item(FUNC_FRAME, 48'h1234_5678_9ABC, 6'd7, 8'd0);
        add_cfg(32'd0);
        add_item(FUNC_TICK, 48'd0, 6'd0, 8'd0);
        // fill the table, then overflow it
        add_cfg(32'hFFFF_FFFF);
        for (int i = 0; i < ENTRIES + 3; i++)
            add_item(FUNC_FRAME, 48'(i) + 48'h0100_0000_0000, 6'($urandom), 8'($urandom));
        for (int i = 0; i < ENTRIES; i++)
            add_item(FUNC_READ, 48'd0, 6'd0, 8'(i));
        add_cfg(32'd3);
        for (int i = 0; i < 3; i++)
            add_item(FUNC_TICK, 48'd0, 6'd0, 8'd0);

        // random phases with varied intervals; small MAC pool gives hits
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: add_cfg(32'd50);
                1: add_cfg(32'd2);
                2: add_cfg(32'd0);
                3: add_cfg(32'hFFFF_FFFF);
                4: add_cfg(32'($urandom_range(5, 200)));
                default: add_cfg(32'd10000);
            endcase
            mac_pool.delete();
            n = $urandom_range(4, 40);
            for (int i = 0; i < n; i++) mac_pool.push_back(48'({$urandom(), $urandom()}));
            for (int i = 0; i < 200; i++) begin
                m = pick_mac();
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: add_item(FUNC_FRAME, m, 6'($urandom), 8'($urandom));
                    5: add_item(FUNC_TICK, m, 6'($urandom), 8'($urandom));
                    6: add_item(FUNC_NONE, m, 6'($urandom), 8'($urandom));
                    default: add_item(FUNC_READ, m, 6'($urandom), 8'($urandom_range(0, 47)));
                endcase
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
    end

    // end of run
    initial begin
        wait (i_rst_n === 1'b1);
        while (pending_q.size() != 0 || expected_q.size() != 0 || start)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        wait (cycles > 900000);
        $display("TEST FAILED");
        $finish;
    end
endmodule
